FILE: rtl/core/per_trigger_hysteresis_debounce_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trigger hysteresis debounce block
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PER_TRIGGER_HYSTERESIS_DEBOUNCE_MACROS_SVH
`define PER_TRIGGER_HYSTERESIS_DEBOUNCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define PHT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hysteresis debounce assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hysteresis debounce assertion failed");

`else

`define PHT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types, constants and helpers of the trigger hysteresis debounce.
// ----------------------------------------------------------------------------
package pht_pkg;

	localparam int CHAN_W               = 6;
	localparam int SCORE_W              = 16;
	localparam int CNT_W                = 8;
	localparam int RATIO_W              = 16;
	localparam int CFG_IDX_W            = 2;
	localparam int CFG_DATA_W           = 16;
	localparam int PROD_W               = 32;
	localparam int DEFAULT_NUM_CHANNELS = 64;
	localparam int OUT_FIFO_DEPTH       = 3;

	// 1e-3 in Q1.15, rounded to nearest
	localparam logic [SCORE_W-1:0] EPS_Q15       = 16'd33;
	localparam logic [CNT_W-1:0]   COUNT_MAX     = 8'hFF;
	localparam logic [CNT_W-1:0]   NEED_RESET    = 8'd1;
	localparam logic [RATIO_W-1:0] RATIO_RESET   = 16'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENTER_NEED = 2'd0,
		REG_EXIT_NEED  = 2'd1,
		REG_RATIO      = 2'd2
	} cfg_reg_t;

	// Per-channel state word held in the state memory
	typedef struct packed {
		logic             active;
		logic [CNT_W-1:0] enter_cnt;
		logic [CNT_W-1:0] exit_cnt;
	} chan_state_t;

	// One result item, packed as on the output tdata (score in the low bits)
	typedef struct packed {
		logic               active;
		logic [SCORE_W-1:0] score;
	} result_t;

	// Saturating counter increment
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == COUNT_MAX) ? COUNT_MAX : c + CNT_W'(1);
	endfunction

endpackage

FILE: rtl/core/pht_state_ram.sv
// ----------------------------------------------------------------------------
// pht_state_ram
// Per-channel state memory: one write and one read port, registered read
// data, write-to-read forwarding and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module pht_state_ram #(
	parameter int NUM_CHANNELS = pht_pkg::DEFAULT_NUM_CHANNELS,
	parameter int AW           = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  pht_pkg::chan_state_t wr_data,
	output pht_pkg::chan_state_t rd_data,
	output logic                busy
);

	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CHANNELS - 1);

	pht_pkg::chan_state_t mem [NUM_CHANNELS];
	pht_pkg::chan_state_t rd_q;
	pht_pkg::chan_state_t fwd_data_q;
	logic                 fwd_q;
	logic                 clr_busy_q;
	logic [AW-1:0]        clr_addr_q;

	// Sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Write port: clearing sweep has the port to itself
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		fwd_data_q <= wr_data;
	end

	// Note a read that collides with a write at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= rd_en && wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : rd_q;
	assign busy    = clr_busy_q;

endmodule

FILE: rtl/core/pht_update.sv
// ----------------------------------------------------------------------------
// pht_update
// Enter/exit counter update, active decision and score adjustment for one
// item, given the channel's current state.
// ----------------------------------------------------------------------------
module pht_update (
	input  pht_pkg::chan_state_t              cur,
	input  logic [pht_pkg::SCORE_W-1:0]       score,
	input  logic [pht_pkg::SCORE_W-1:0]       thr,
	input  logic [pht_pkg::PROD_W-1:0]        thr_ratio,
	input  logic                              at_or_above,
	input  logic [pht_pkg::CNT_W-1:0]         enter_need,
	input  logic [pht_pkg::CNT_W-1:0]         exit_need,
	output pht_pkg::chan_state_t              nxt,
	output pht_pkg::result_t                  res
);

	logic [pht_pkg::CNT_W-1:0]  need_in;
	logic [pht_pkg::CNT_W-1:0]  need_out;
	logic [pht_pkg::PROD_W-1:0] score_scaled;
	logic                       below_release;
	logic                       confirmed;

	// Treat a zero count requirement as one
	assign need_in  = (enter_need == '0) ? pht_pkg::CNT_W'(1) : enter_need;
	assign need_out = (exit_need == '0) ? pht_pkg::CNT_W'(1) : exit_need;

	// score * 32768 < threshold * release_ratio
	assign score_scaled  = pht_pkg::PROD_W'({score, 15'b0});
	assign below_release = score_scaled < thr_ratio;

	// Advance counters and decide the active flag
	always_comb begin
		nxt = cur;
		if (!cur.active) begin
			if (at_or_above) begin
				nxt.enter_cnt = pht_pkg::sat_inc(cur.enter_cnt);
				confirmed     = nxt.enter_cnt >= need_in;
			end else begin
				nxt.enter_cnt = '0;
				confirmed     = 1'b0;
			end
			nxt.exit_cnt = '0;
		end else begin
			if (below_release) begin
				nxt.exit_cnt = pht_pkg::sat_inc(cur.exit_cnt);
				confirmed    = nxt.exit_cnt < need_out;
			end else begin
				nxt.exit_cnt = '0;
				confirmed    = 1'b1;
			end
			nxt.enter_cnt = '0;
		end
		nxt.active = confirmed;
	end

	// Cap an unconfirmed score below threshold, raise a confirmed one to it
	always_comb begin
		res.active = confirmed;
		if (!confirmed && at_or_above) begin
			res.score = (thr >= pht_pkg::EPS_Q15) ? thr - pht_pkg::EPS_Q15 : '0;
		end else if (confirmed && !at_or_above) begin
			res.score = thr;
		end else begin
			res.score = score;
		end
	end

endmodule

FILE: rtl/core/pht_out_fifo.sv
// ----------------------------------------------------------------------------
// pht_out_fifo
// Small result queue that decouples the output handshake from the pipeline.
// ----------------------------------------------------------------------------
module pht_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pht_pkg::result_t push_data,
	input  logic             pop,
	output pht_pkg::result_t head,
	output logic             not_empty,
	output logic [1:0]       count
);

	localparam int DEPTH = pht_pkg::OUT_FIFO_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	pht_pkg::result_t slots_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [1:0]       count_q;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign head      = slots_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

endmodule

FILE: rtl/core/per_trigger_hysteresis_debounce.sv
// ----------------------------------------------------------------------------
// per_trigger_hysteresis_debounce
// Per-channel enter/exit count hysteresis on trigger scores, state kept in a
// synchronous memory with read-modify-write and forwarding.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload (low bit up)                          Handshake
// s_axis    in   channel[5:0] score_in[21:6] threshold[37:22]  tvalid/tready
// m_axis    out  score_out[15:0] active[16]                    tvalid/tready
// cfg       in   cfg_index selects register, cfg_data value    cfg_we
//
// One item per cycle sustained while m_axis_tready is high; each result
// passes the memory read, then update and write-back to the result queue.
// After reset the state memory is swept to zero while s_axis_tready stays
// low; configuration writes are taken throughout.
// s_axis_tready depends only on the registered sweep flag and occupancy of
// the pipeline stage and three-entry result queue, never on m_axis_tready.
// ----------------------------------------------------------------------------
module per_trigger_hysteresis_debounce #(
	parameter int NUM_CHANNELS = pht_pkg::DEFAULT_NUM_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	// channel, score_in, threshold
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// score_out, active
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic                              cfg_we,
	input  logic [pht_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pht_pkg::CFG_DATA_W-1:0]    cfg_data
);

	`include "per_trigger_hysteresis_debounce_macros.svh"

	localparam int AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CW   = pht_pkg::CHAN_W;
	localparam int SW   = pht_pkg::SCORE_W;
	localparam int EXTW = AW + CW;

	// Configuration registers
	logic [pht_pkg::CNT_W-1:0]   enter_need_q;
	logic [pht_pkg::CNT_W-1:0]   exit_need_q;
	logic [pht_pkg::RATIO_W-1:0] ratio_q;

	// Input fields
	logic [CW-1:0]   in_channel;
	logic [SW-1:0]   in_score;
	logic [SW-1:0]   in_thr;
	logic [EXTW-1:0] ch_ext;
	logic            in_range;
	logic            s_accept;

	// Pipeline stage 1: memory read in flight
	logic                        valid_s1;
	logic                        in_range_s1;
	logic [AW-1:0]               addr_s1;
	logic [SW-1:0]               score_s1;
	logic [SW-1:0]               thr_s1;
	logic [pht_pkg::PROD_W-1:0]  prod_s1;
	logic                        ge_s1;

	pht_pkg::chan_state_t cur_state;
	pht_pkg::chan_state_t nxt_state;
	pht_pkg::result_t     upd_res;
	pht_pkg::result_t     push_res;
	pht_pkg::result_t     head_res;
	logic                 state_wr_en;
	logic                 clr_busy;
	logic                 fifo_not_empty;
	logic [1:0]           fifo_count;
	logic                 m_pop;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_need_q <= pht_pkg::NEED_RESET;
			exit_need_q  <= pht_pkg::NEED_RESET;
			ratio_q      <= pht_pkg::RATIO_RESET;
		end else if (cfg_we) begin
			unique case (pht_pkg::cfg_reg_t'(cfg_index))
				pht_pkg::REG_ENTER_NEED: begin
					enter_need_q <= cfg_data[pht_pkg::CNT_W-1:0];
				end
				pht_pkg::REG_EXIT_NEED: begin
					exit_need_q <= cfg_data[pht_pkg::CNT_W-1:0];
				end
				pht_pkg::REG_RATIO: begin
					ratio_q <= cfg_data[pht_pkg::RATIO_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Unpack the input transaction
	assign in_channel = s_axis_tdata[CW-1:0];
	assign in_score   = s_axis_tdata[CW+SW-1:CW];
	assign in_thr     = s_axis_tdata[CW+2*SW-1:CW+SW];
	assign ch_ext     = EXTW'(in_channel);
	assign in_range   = ch_ext < EXTW'(NUM_CHANNELS);

	// Accept while the stage and queue together leave a free result slot
	assign s_axis_tready = !clr_busy &&
		((3'(fifo_count) + 3'(valid_s1)) < 3'(pht_pkg::OUT_FIFO_DEPTH));
	assign s_accept = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_accept;
		end
	end

	// Hold item fields and the release product while the read completes
	always_ff @(posedge clk) begin
		if (s_accept) begin
			in_range_s1 <= in_range;
			addr_s1     <= ch_ext[AW-1:0];
			score_s1    <= in_score;
			thr_s1      <= in_thr;
			prod_s1     <= pht_pkg::PROD_W'(in_thr) * pht_pkg::PROD_W'(ratio_q);
			ge_s1       <= in_score >= in_thr;
		end
	end

	pht_state_ram #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.AW          (AW)
	) u_state_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (s_accept && in_range),
		.rd_addr(ch_ext[AW-1:0]),
		.wr_en  (state_wr_en),
		.wr_addr(addr_s1),
		.wr_data(nxt_state),
		.rd_data(cur_state),
		.busy   (clr_busy)
	);

	pht_update u_update (
		.cur        (cur_state),
		.score      (score_s1),
		.thr        (thr_s1),
		.thr_ratio  (prod_s1),
		.at_or_above(ge_s1),
		.enter_need (enter_need_q),
		.exit_need  (exit_need_q),
		.nxt        (nxt_state),
		.res        (upd_res)
	);

	// Write back the updated state; pass out-of-range channels straight through
	assign state_wr_en = valid_s1 && in_range_s1;

	always_comb begin
		if (in_range_s1) begin
			push_res = upd_res;
		end else begin
			push_res.score  = score_s1;
			push_res.active = 1'b0;
		end
	end

	assign m_pop = m_axis_tvalid && m_axis_tready;

	pht_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s1),
		.push_data(push_res),
		.pop      (m_pop),
		.head     (head_res),
		.not_empty(fifo_not_empty),
		.count    (fifo_count)
	);

	assign m_axis_tvalid = fifo_not_empty;
	assign m_axis_tdata  = 24'(head_res);

	// Result queue never overflows
	`PHT_ASSERT_IMPLIES(a_no_overflow, clk, arst_n, valid_s1, (fifo_count != 2'd3) || m_pop)
	// In-flight items never exceed the queue depth
	`PHT_ASSERT_IMPLIES(a_credit, clk, arst_n, 1'b1, (3'(fifo_count) + 3'(valid_s1)) <= 3'd3)
	// No state write-back while the clearing sweep owns the memory
	`PHT_ASSERT_IMPLIES(a_no_write_in_clear, clk, arst_n, clr_busy, !state_wr_en)

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for per_trigger_hysteresis_debounce
// Drives scored trigger items into the stream input and checks every result
// against a cycle-free predictor of the per-channel enter/exit debounce.
// Covers directed corners, long runs on the largest counts and random runs
// under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH         = pht_pkg::DEFAULT_NUM_CHANNELS;
	localparam int QUIET_LIMIT    = 1000;
	localparam int RX_HOLD_CYCLES = 60;
	localparam int MAX_REPORTS    = 10;
	localparam logic [pht_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// One input transaction, channel in the low bits
	typedef struct packed {
		logic [pht_pkg::SCORE_W-1:0] thr;
		logic [pht_pkg::SCORE_W-1:0] score;
		logic [pht_pkg::CHAN_W-1:0]  ch;
	} trig_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	// channel[5:0], score_in[21:6], threshold[37:22]
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// score_out[15:0], active[16]
	logic [23:0] m_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [pht_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pht_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	per_trigger_hysteresis_debounce u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor copy of the registers and per-channel state
	logic [pht_pkg::CNT_W-1:0]   cfg_enter_need = pht_pkg::NEED_RESET;
	logic [pht_pkg::CNT_W-1:0]   cfg_exit_need = pht_pkg::NEED_RESET;
	logic [pht_pkg::RATIO_W-1:0] cfg_ratio = pht_pkg::RATIO_RESET;
	logic                        chan_active [NUM_CH] = '{default: 1'b0};
	logic [pht_pkg::CNT_W-1:0]   chan_enter [NUM_CH] = '{default: '0};
	logic [pht_pkg::CNT_W-1:0]   chan_exit [NUM_CH] = '{default: '0};

	trig_item_t        pending_items [$];
	pht_pkg::result_t  expected_results [$];
	trig_item_t        cur_item;
	int unsigned n_queued = 0;
	int unsigned n_sent = 0;
	int unsigned n_recv = 0;
	int unsigned n_cfg = 0;
	int unsigned n_errors = 0;
	int unsigned n_activations = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	int unsigned rx_hold = 0;
	int unsigned rx_hold_requests = 0;
	int unsigned rx_hold_served = 0;
	bit          idle_en = 1'b1;

	// Work out the debounced result of one item and advance the channel state
	function automatic pht_pkg::result_t predict_debounce(trig_item_t it);
		logic [pht_pkg::CNT_W-1:0]  need_in;
		logic [pht_pkg::CNT_W-1:0]  need_out;
		logic [pht_pkg::PROD_W-1:0] scaled;
		logic [pht_pkg::PROD_W-1:0] release_level;
		logic                       confirmed;
		pht_pkg::result_t           r;
		need_in = (cfg_enter_need == '0) ? pht_pkg::CNT_W'(1) : cfg_enter_need;
		need_out = (cfg_exit_need == '0) ? pht_pkg::CNT_W'(1) : cfg_exit_need;
		r.score = it.score;
		r.active = 1'b0;
		if (it.ch >= NUM_CH)
			return r;
		if (!chan_active[it.ch]) begin
			if (it.score >= it.thr) begin
				if (chan_enter[it.ch] != pht_pkg::COUNT_MAX)
					chan_enter[it.ch] = chan_enter[it.ch] + 1'b1;
				confirmed = (chan_enter[it.ch] >= need_in);
			end else begin
				chan_enter[it.ch] = '0;
				confirmed = 1'b0;
			end
			chan_exit[it.ch] = '0;
		end else begin
			scaled = {1'b0, it.score, 15'd0};
			release_level = pht_pkg::PROD_W'(it.thr) * pht_pkg::PROD_W'(cfg_ratio);
			if (scaled < release_level) begin
				if (chan_exit[it.ch] != pht_pkg::COUNT_MAX)
					chan_exit[it.ch] = chan_exit[it.ch] + 1'b1;
				confirmed = (chan_exit[it.ch] < need_out);
			end else begin
				chan_exit[it.ch] = '0;
				confirmed = 1'b1;
			end
			chan_enter[it.ch] = '0;
		end
		chan_active[it.ch] = confirmed;
		// Cap unconfirmed scores just under threshold, lift confirmed ones to it
		if (!confirmed && it.score >= it.thr)
			r.score = (it.thr >= pht_pkg::EPS_Q15) ? it.thr - pht_pkg::EPS_Q15 : '0;
		else if (confirmed && it.score < it.thr)
			r.score = it.thr;
		r.active = confirmed;
		return r;
	endfunction

	task automatic report_failure(string what);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("[%0t] FAIL: %s", $realtime, what);
	endtask

	// Drive transactions: hold until accepted, then wait a drawn gap
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.insert(expected_results.size(), predict_debounce(cur_item));
				n_sent++;
				tx_gap = idle_en ? $urandom_range(0, 3) : 0;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {2'b00, cur_item};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check results in order and pace the ready line
	always @(posedge clk) begin
		pht_pkg::result_t got;
		pht_pkg::result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = pht_pkg::result_t'(m_axis_tdata[16:0]);
				n_recv++;
				if (expected_results.size() == 0) begin
					report_failure($sformatf("result score=%0d active=%0b with none expected",
						got.score, got.active));
				end else begin
					want = expected_results.pop_front();
					if (got.active)
						n_activations++;
					if (got.score != want.score || got.active != want.active)
						report_failure($sformatf(
							"result %0d: score exp %0d got %0d, active exp %0b got %0b",
							n_recv, want.score, got.score, want.active, got.active));
				end
				rx_gap = idle_en ? $urandom_range(0, 3) : 0;
			end
			if (rx_hold_served != rx_hold_requests) begin
				rx_hold_served++;
				rx_hold = RX_HOLD_CYCLES;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// End the run when no transaction moves for too long
	initial begin : watchdog
		int unsigned quiet;
		int unsigned seen;
		quiet = 0;
		seen = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if (n_sent + n_recv + n_cfg != seen) begin
				seen = n_sent + n_recv + n_cfg;
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("testbench: done, errors");
		$finish;
	end

	task automatic push_item(logic [pht_pkg::CHAN_W-1:0] ch,
			logic [pht_pkg::SCORE_W-1:0] score, logic [pht_pkg::SCORE_W-1:0] thr);
		trig_item_t it;
		it.ch = ch;
		it.score = score;
		it.thr = thr;
		pending_items.insert(pending_items.size(), it);
		n_queued++;
	endtask

	// Write one register; only called with the block drained
	task automatic cfg_write(logic [pht_pkg::CFG_IDX_W-1:0] idx,
			logic [pht_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (pht_pkg::cfg_reg_t'(idx))
			pht_pkg::REG_ENTER_NEED: cfg_enter_need = value[pht_pkg::CNT_W-1:0];
			pht_pkg::REG_EXIT_NEED:  cfg_exit_need = value[pht_pkg::CNT_W-1:0];
			pht_pkg::REG_RATIO:      cfg_ratio = value;
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [pht_pkg::SCORE_W-1:0] pick_threshold();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return pht_pkg::EPS_Q15;
			2: return pht_pkg::SCORE_W'(32768);
			3: return '1;
			4: return pht_pkg::SCORE_W'($urandom_range(0, 40));
			default: return pht_pkg::SCORE_W'($urandom());
		endcase
	endfunction

	// Score that counts toward release of an active channel, when one exists
	function automatic logic [pht_pkg::SCORE_W-1:0] low_score(
			logic [pht_pkg::SCORE_W-1:0] thr);
		longint unsigned lim;
		lim = longint'(thr) * longint'(cfg_ratio);
		if (lim == 0)
			return pht_pkg::SCORE_W'($urandom());
		lim = (lim - 1) >> 15;
		if (lim > 65535)
			lim = 65535;
		return pht_pkg::SCORE_W'($urandom_range(0, int'(lim)));
	endfunction

	// Push one run item, sometimes preceded by noise or replaced by a break
	task automatic push_in_run(logic [pht_pkg::CHAN_W-1:0] ch,
			logic [pht_pkg::SCORE_W-1:0] score, logic [pht_pkg::SCORE_W-1:0] thr);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			push_item(ch + pht_pkg::CHAN_W'($urandom_range(1, NUM_CH - 1)),
				pht_pkg::SCORE_W'($urandom()), pick_threshold());
		if (roll >= 95)
			push_item(ch, pht_pkg::SCORE_W'($urandom()), thr);
		else
			push_item(ch, score, thr);
	endtask

	// Mostly enter/exit runs on one channel at a time, the rest loose items
	task automatic random_phase(int unsigned n_items);
		int unsigned                 target;
		int unsigned                 need_in;
		int unsigned                 need_out;
		int unsigned                 n_high;
		int unsigned                 n_low;
		logic [pht_pkg::CHAN_W-1:0]  ch;
		logic [pht_pkg::SCORE_W-1:0] thr;
		target = n_queued + n_items;
		need_in = (cfg_enter_need == '0) ? 1 : cfg_enter_need;
		need_out = (cfg_exit_need == '0) ? 1 : cfg_exit_need;
		while (n_queued < target) begin
			if ($urandom_range(0, 9) < 8) begin
				ch = pht_pkg::CHAN_W'($urandom());
				thr = pick_threshold();
				n_high = $urandom_range(0, need_in + 1);
				n_low = $urandom_range(0, need_out + 1);
				repeat (n_high)
					push_in_run(ch, pht_pkg::SCORE_W'($urandom_range(thr, 16'hFFFF)), thr);
				repeat (n_low)
					push_in_run(ch, low_score(thr), thr);
			end else begin
				push_item(pht_pkg::CHAN_W'($urandom()), pht_pkg::SCORE_W'($urandom()),
					pht_pkg::SCORE_W'($urandom()));
			end
		end
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero scores, full-scale values, release on the edge
		push_item(6'd0, 16'd0, 16'd0);
		push_item(6'd0, 16'd0, 16'd0);
		push_item(6'd1, 16'hFFFF, 16'hFFFF);
		push_item(6'd1, 16'd0, 16'hFFFF);
		push_item(6'd2, 16'd100, 16'd200);
		push_item(6'd3, 16'd32768, 16'd32768);
		push_item(6'd3, 16'd32767, 16'd32768);
		push_item(6'd63, 16'hFFFF, 16'd0);
		push_item(6'd63, 16'd0, 16'd1);
		wait_drained();

		// Slower enter and exit, half-threshold release
		cfg_write(pht_pkg::REG_ENTER_NEED, 16'd3);
		cfg_write(pht_pkg::REG_EXIT_NEED, 16'd2);
		cfg_write(pht_pkg::REG_RATIO, 16'd16384);
		// Threshold under epsilon caps to zero until confirmed
		repeat (3) push_item(6'd4, 16'd20, 16'd10);
		// Score exactly at the release level keeps the channel held
		push_item(6'd4, 16'd5, 16'd10);
		push_item(6'd4, 16'd4, 16'd10);
		push_item(6'd4, 16'd4, 16'd10);
		push_item(6'd5, 16'hFFFF, 16'hFFFF);
		push_item(6'd5, 16'd33, 16'd33);
		push_item(6'd5, 16'd40, 16'd34);
		push_item(6'd5, 16'd0, 16'd34);
		random_phase(200);
		wait_drained();

		// Longest runs, no idling on either side
		cfg_write(pht_pkg::REG_ENTER_NEED, 16'd255);
		cfg_write(pht_pkg::REG_EXIT_NEED, 16'd255);
		cfg_write(pht_pkg::REG_RATIO, 16'hFFFF);
		@(negedge clk);
		idle_en = 1'b0;
		repeat (258) push_item(6'd7, pht_pkg::SCORE_W'($urandom_range(16'h4000, 16'hFFFF)),
			16'h4000);
		repeat (258) push_item(6'd7, low_score(16'h4000), 16'h4000);
		wait_drained();
		idle_en = 1'b1;

		// Zero counts act as one; zero ratio never counts toward release
		cfg_write(pht_pkg::REG_ENTER_NEED, 16'd0);
		cfg_write(pht_pkg::REG_EXIT_NEED, 16'd0);
		cfg_write(pht_pkg::REG_RATIO, 16'd0);
		random_phase(150);
		wait_drained();

		// Ignored register index, then a long receiver hold-off mid-stream
		cfg_write(REG_UNUSED, 16'hFFFF);
		cfg_write(pht_pkg::REG_ENTER_NEED, 16'd5);
		cfg_write(pht_pkg::REG_EXIT_NEED, 16'd3);
		cfg_write(pht_pkg::REG_RATIO, pht_pkg::CFG_DATA_W'($urandom()));
		random_phase(150);
		rx_hold_requests++;
		wait_drained();
		random_phase(150);
		wait_drained();

		// Upper data bits on the count registers are dropped
		cfg_write(pht_pkg::REG_ENTER_NEED, 16'hAB01);
		cfg_write(pht_pkg::REG_EXIT_NEED, 16'h5402);
		cfg_write(pht_pkg::REG_RATIO, 16'd32768);
		random_phase(200);
		wait_drained();

		repeat (8) @(negedge clk);
		if (expected_results.size() != 0)
			report_failure($sformatf("%0d results never arrived", expected_results.size()));
		$display("summary: %0d items in, %0d results checked (%0d active), %0d register writes",
			n_sent, n_recv, n_activations, n_cfg);
		$display("summary: counts 0..255, ratio 0..65535, corner thresholds, %0d failures",
			n_errors);
		if (n_errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
